// File: rtl/sls_pkg.sv
// ----------------------------------------------------------------------------
// sls_pkg: shared types and constants for the sprite line search
// Holds the controller state encoding, the command and status groups that
// join controller and datapath, and the fixed offsets of the object format.
// ----------------------------------------------------------------------------
`default_nettype none

package sls_pkg;

   // Opcodes of an input item
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // Object format offsets and heights
   localparam logic [7:0] Y_OFFSET     = 8'd16;
   localparam logic [7:0] X_OFFSET     = 8'd8;
   localparam logic [8:0] SHORT_HEIGHT = 9'd8;
   localparam logic [8:0] TALL_HEIGHT  = 9'd16;

   // Width of the slot field on the result port
   localparam int SLOT_W = 4;

   // Controller states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic write;   // store one attribute byte from the request ports
      logic load;    // capture the scanline, clear the scan state
      logic issue;   // read the current entry and advance the entry counter
      logic finish;  // emit the closing result of a search
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic last_entry;  // entry counter points at the final whole entry
      logic full;        // the per-line match limit has been reached
   } status_type;

endpackage

`default_nettype wire

// File: rtl/sls_ctrl.sv
// ----------------------------------------------------------------------------
// sls_ctrl: sequencer of the sprite line search
// Accepts request items, runs writes in the idle state and steps a search
// through scan, drain and finish.
// ----------------------------------------------------------------------------
`default_nettype none

module sls_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  wire                  req_op,
   input  sls_pkg::status_type  status,
   output logic                 busy,
   output sls_pkg::cmd_type     cmd
);

   sls_pkg::state_type state_ff;
   sls_pkg::state_type state_in;
   logic               accept;

   assign busy   = (state_ff != sls_pkg::ST_IDLE);
   assign accept = start && !busy;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      unique case (state_ff)
         sls_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_op == sls_pkg::OP_SEARCH) begin
                  cmd.load = 1'b1;
                  state_in = sls_pkg::ST_SCAN;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         sls_pkg::ST_SCAN: begin
            cmd.issue = !status.full;
            if (status.full || status.last_entry) begin
               state_in = sls_pkg::ST_DRAIN;
            end
         end
         sls_pkg::ST_DRAIN: begin
            state_in = sls_pkg::ST_FINISH;
         end
         sls_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = sls_pkg::ST_IDLE;
         end
         default: begin
            state_in = sls_pkg::ST_IDLE;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sls_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/sls_datapath.sv
// ----------------------------------------------------------------------------
// sls_datapath: attribute store, match test and result register
// Keeps the object attribute memory with per-byte valid bits, reads one
// entry per scan step, tests it against the scanline and emits matches one
// behind so that the final one can carry the last flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sls_datapath #(
   parameter int STORE_BYTES  = 160,
   parameter int MAX_PER_LINE = 10
) (
   input  wire                  clock,
   input  wire                  reset,
   input  sls_pkg::cmd_type     cmd,
   output sls_pkg::status_type  status,
   input  wire  [7:0]           req_oam_index,
   input  wire  [7:0]           req_oam_byte,
   input  wire  [7:0]           req_scanline,
   input  wire                  csr_valid,
   input  wire                  csr_ready,
   input  wire                  csr_tall_objects,
   output logic                 rsp_strobe,
   output logic                 rsp_found,
   output logic [3:0]           rsp_slot,
   output logic [7:0]           rsp_tile_id,
   output logic [7:0]           rsp_x_pos,
   output logic [7:0]           rsp_y_pos,
   output logic [7:0]           rsp_attributes,
   output logic                 rsp_last
);

   localparam int NUM_ENTRIES = STORE_BYTES / 4;
   localparam int EIDX_W      = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_PER_LINE + 1);
   localparam int WHOLE_BYTES = NUM_ENTRIES * 4;

   // Attribute memory, one word per entry, and per-byte valid bits
   logic [31:0]       mem_ff   [NUM_ENTRIES];
   logic [3:0]        valid_ff [NUM_ENTRIES];

   logic              tall_ff;
   logic [7:0]        line_ff;
   logic [EIDX_W-1:0] entry_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              rd_pend_ff;
   logic [31:0]       rd_data_ff;
   logic [3:0]        rd_vbits_ff;

   // Pending match, held until the next match or the end of the search
   logic              pend_v_ff;
   logic [3:0]        pend_slot_ff;
   logic [7:0]        pend_tile_ff;
   logic [7:0]        pend_x_ff;
   logic [7:0]        pend_y_ff;
   logic [7:0]        pend_attr_ff;

   // Result register
   logic              rsp_strobe_ff;
   logic              rsp_found_ff;
   logic [3:0]        rsp_slot_ff;
   logic [7:0]        rsp_tile_ff;
   logic [7:0]        rsp_x_ff;
   logic [7:0]        rsp_y_ff;
   logic [7:0]        rsp_attr_ff;
   logic              rsp_last_ff;

   logic              wr_hit;
   logic [EIDX_W-1:0] wr_entry;
   logic [1:0]        wr_field;
   logic [7:0]        raw_y;
   logic [7:0]        raw_x;
   logic [7:0]        raw_tile;
   logic [7:0]        raw_attr;
   logic [7:0]        obj_y;
   logic [7:0]        obj_x;
   logic [8:0]        obj_bottom;
   logic              match;
   logic              eval_hit;
   logic [CNT_W+3:0]  count_ext;

   // Decode the write address into entry and byte lane
   assign wr_hit   = cmd.write && ({1'b0, req_oam_index} < 9'(WHOLE_BYTES));
   assign wr_entry = req_oam_index[2 +: EIDX_W];
   assign wr_field = req_oam_index[1:0];

   // Mask bytes never written to their reset value of zero
   assign raw_y    = rd_vbits_ff[0] ? rd_data_ff[7:0]   : 8'd0;
   assign raw_x    = rd_vbits_ff[1] ? rd_data_ff[15:8]  : 8'd0;
   assign raw_tile = rd_vbits_ff[2] ? rd_data_ff[23:16] : 8'd0;
   assign raw_attr = rd_vbits_ff[3] ? rd_data_ff[31:24] : 8'd0;

   // Test the entry against the scanline; the bottom edge does not wrap
   assign obj_y      = raw_y - sls_pkg::Y_OFFSET;
   assign obj_x      = raw_x - sls_pkg::X_OFFSET;
   assign obj_bottom = {1'b0, obj_y}
                       + (tall_ff ? sls_pkg::TALL_HEIGHT : sls_pkg::SHORT_HEIGHT);
   assign match      = (line_ff >= obj_y) && ({1'b0, line_ff} < obj_bottom)
                       && (raw_x > sls_pkg::X_OFFSET);
   assign eval_hit   = rd_pend_ff && !status.full && match;
   assign count_ext  = {4'd0, count_ff};

   assign status.full       = (count_ff == CNT_W'(MAX_PER_LINE));
   assign status.last_entry = (entry_ff == EIDX_W'(NUM_ENTRIES - 1));

   // Store a byte into the memory
   always_ff @(posedge clock) begin
      if (wr_hit) begin
         mem_ff[wr_entry][wr_field*8 +: 8] <= req_oam_byte;
      end
   end

   // Read one entry per scan step
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_data_ff  <= mem_ff[entry_ff];
         rd_vbits_ff <= valid_ff[entry_ff];
      end
   end

   // Mark written bytes valid; reset clears the whole store at once
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            valid_ff[i] <= 4'd0;
         end
      end else if (wr_hit) begin
         valid_ff[wr_entry][wr_field] <= 1'b1;
      end
   end

   // Object height register
   always_ff @(posedge clock) begin
      if (reset) begin
         tall_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         tall_ff <= csr_tall_objects;
      end
   end

   // Scan control: entry counter, read pipe flag, match count
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff   <= '0;
         count_ff   <= '0;
         rd_pend_ff <= 1'b0;
         pend_v_ff  <= 1'b0;
      end else if (cmd.load) begin
         entry_ff   <= '0;
         count_ff   <= '0;
         rd_pend_ff <= 1'b0;
         pend_v_ff  <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.issue;
         if (cmd.issue) begin
            entry_ff <= entry_ff + 1'b1;
         end
         if (eval_hit) begin
            count_ff  <= count_ff + 1'b1;
            pend_v_ff <= 1'b1;
         end
         if (cmd.finish) begin
            pend_v_ff <= 1'b0;
         end
      end
   end

   // Capture the search line
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         line_ff <= req_scanline;
      end
   end

   // Hold the newest match as pending
   always_ff @(posedge clock) begin
      if (eval_hit) begin
         pend_slot_ff <= count_ext[3:0];
         pend_tile_ff <= raw_tile;
         pend_x_ff    <= obj_x;
         pend_y_ff    <= obj_y;
         pend_attr_ff <= raw_attr;
      end
   end

   // Result strobe: an older match on a new hit, the closing result on finish
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (eval_hit && pend_v_ff) || cmd.finish;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (cmd.finish && !pend_v_ff) begin
         rsp_found_ff <= 1'b0;
         rsp_slot_ff  <= 4'd0;
         rsp_tile_ff  <= 8'd0;
         rsp_x_ff     <= 8'd0;
         rsp_y_ff     <= 8'd0;
         rsp_attr_ff  <= 8'd0;
         rsp_last_ff  <= 1'b1;
      end else begin
         rsp_found_ff <= 1'b1;
         rsp_slot_ff  <= pend_slot_ff;
         rsp_tile_ff  <= pend_tile_ff;
         rsp_x_ff     <= pend_x_ff;
         rsp_y_ff     <= pend_y_ff;
         rsp_attr_ff  <= pend_attr_ff;
         rsp_last_ff  <= cmd.finish;
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_tile_id    = rsp_tile_ff;
   assign rsp_x_pos      = rsp_x_ff;
   assign rsp_y_pos      = rsp_y_ff;
   assign rsp_attributes = rsp_attr_ff;
   assign rsp_last       = rsp_last_ff;

   // The match count never passes the per-line limit
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_PER_LINE))
      else $error("match count above limit");

   // Finishing a search always yields the closing result next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (rsp_strobe_ff && rsp_last_ff))
      else $error("finish without closing result");

   // A hit behind a pending match pushes out a non-final found result
   assert property (@(posedge clock) disable iff (reset)
      (eval_hit && pend_v_ff) |=> (rsp_strobe_ff && rsp_found_ff && !rsp_last_ff))
      else $error("pending match not emitted");

   // A not-found result is always the only and final one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && !rsp_found_ff) |-> (rsp_last_ff && $past(count_ff) == '0))
      else $error("not-found result out of place");

endmodule

`default_nettype wire

// File: rtl/sprite_line_search.sv
// ----------------------------------------------------------------------------
// sprite_line_search: object attribute scan for one display line
// Holds the object attribute store, takes byte writes and scanline
// searches, and streams the selected objects of a line in store order.
//
//   channel   ports                            handshake
//   request   req_op/oam_index/oam_byte/       accepted when start && !busy
//             req_scanline
//   result    rsp_found/slot/tile_id/x_pos/    one cycle per item, rsp_strobe
//             y_pos/attributes/last
//   config    csr_tall_objects                 written when csr_valid && csr_ready
//
// A write item is stored in the idle state; the next item can be accepted right after.
// A search item reads one entry per cycle from the entry memory (N = STORE_BYTES / 4
// entries, 40 by default); the scan stops early when the per-line limit is reached.
// Results leave one behind the scan; the last one appears in the same cycle as
// busy falls. The receiver cannot stall results.
// Reset clears the store through per-byte valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_line_search #(
   parameter int STORE_BYTES  = 160,
   parameter int MAX_PER_LINE = 10
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        start,
   output logic       busy,
   input  wire        req_op,
   input  wire  [7:0] req_oam_index,
   input  wire  [7:0] req_oam_byte,
   input  wire  [7:0] req_scanline,
   output logic       rsp_strobe,
   output logic       rsp_found,
   output logic [3:0] rsp_slot,
   output logic [7:0] rsp_tile_id,
   output logic [7:0] rsp_x_pos,
   output logic [7:0] rsp_y_pos,
   output logic [7:0] rsp_attributes,
   output logic       rsp_last,
   input  wire        csr_valid,
   output logic       csr_ready,
   input  wire        csr_tall_objects
);

   sls_pkg::cmd_type    cmd;
   sls_pkg::status_type status;

   // Take configuration while no search runs
   assign csr_ready = !busy;

   sls_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   sls_datapath #(
      .STORE_BYTES  (STORE_BYTES),
      .MAX_PER_LINE (MAX_PER_LINE)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_oam_index    (req_oam_index),
      .req_oam_byte     (req_oam_byte),
      .req_scanline     (req_scanline),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_tall_objects (csr_tall_objects),
      .rsp_strobe       (rsp_strobe),
      .rsp_found        (rsp_found),
      .rsp_slot         (rsp_slot),
      .rsp_tile_id      (rsp_tile_id),
      .rsp_x_pos        (rsp_x_pos),
      .rsp_y_pos        (rsp_y_pos),
      .rsp_attributes   (rsp_attributes),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire
